/* hdl/tsgp_pkg.sv */
package tsgp_pkg;

    // default parameter values
    localparam int DEF_CHANNELS    = 2;
    localparam int DEF_SAMPLE_BITS = 24;

    // configuration port geometry
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PHASE_STEP      = 8'd0,
        REG_PHASE_SHIFT     = 8'd1,
        REG_PUMP_AMOUNT     = 8'd2,
        REG_ACTIVE_CHANNELS = 8'd3
    } reg_idx_t;

    // register reset values
    localparam logic [31:0] RST_PHASE_STEP      = 32'd178957;
    localparam logic [16:0] RST_PHASE_SHIFT     = 17'd0;
    localparam logic [16:0] RST_PUMP_AMOUNT     = 17'd0;
    localparam logic [1:0]  RST_ACTIVE_CHANNELS = 2'd2;

    // envelope constants, q1.16 unless noted
    localparam logic [31:0] SPLIT_D     = 32'd1202590843;  // 0.28 of a cycle over 2^32
    localparam logic [31:0] SPLIT_R     = 32'd3092376453;  // rest of the cycle
    localparam logic [16:0] UNITY       = 17'd65536;
    localparam logic [16:0] FLOOR_MIN   = 17'd3277;
    localparam logic [16:0] NINE_TENTHS = 17'd58982;
    localparam logic [16:0] BYPASS_MAX  = 17'd6;
    localparam logic [17:0] SMOOTH_3    = 18'd196608;      // 3.0 in q2.16
    localparam int          ROUND_HALF  = 32768;
    localparam int          FRAC_BITS   = 16;

    // reciprocals for the phase-to-t quotient, floor(2^48 / divisor)
    localparam logic [17:0] RECIP_D     = 18'd234057;
    localparam logic [17:0] RECIP_R     = 18'd91022;
    localparam int          RECIP_SHIFT = 32;

    // configuration as seen by the datapath
    typedef struct packed {
        logic [31:0] phase_step;
        logic [16:0] phase_shift;
        logic [16:0] pump_amount;
        logic [1:0]  active_channels;
    } cfg_t;

    // shared multiplier operations
    typedef enum logic [3:0] {
        OP_AMT_SQ = 4'd0,
        OP_FLOOR  = 4'd1,
        OP_SHAPE1 = 4'd2,
        OP_SHAPE2 = 4'd3,
        OP_GAIN   = 4'd4,
        OP_LEFT   = 4'd5,
        OP_RIGHT  = 4'd6,
        OP_RECIP  = 4'd7,
        OP_BACK   = 4'd8
    } mul_op_t;

    // controller to datapath commands
    typedef struct packed {
        logic    take;
        logic    prep;
        logic    mul_en;
        logic    wb_en;
        mul_op_t op;
        logic    out_load;
    } cmd_t;

endpackage

/* hdl/tsgp_dp.sv */
module tsgp_dp #(
    parameter int CHANNELS    = tsgp_pkg::DEF_CHANNELS,
    parameter int SAMPLE_BITS = tsgp_pkg::DEF_SAMPLE_BITS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  tsgp_pkg::cfg_t                cfg,
    input  tsgp_pkg::cmd_t                cmd,
    input  logic signed [SAMPLE_BITS-1:0] in_left,
    input  logic signed [SAMPLE_BITS-1:0] in_right,
    output logic signed [SAMPLE_BITS-1:0] out_left,
    output logic signed [SAMPLE_BITS-1:0] out_right,
    output logic [16:0]                   gain_now
);
    import tsgp_pkg::*;

    localparam int SB  = SAMPLE_BITS;
    localparam int MAW = ((SB > 32) ? SB : 32) + 1;
    localparam int MBW = 19;
    localparam int PW  = MAW + MBW;

    // phase and work registers
    logic [31:0]          phase_reg;
    logic [31:0]          p_reg;
    logic signed [SB-1:0] samp_l_reg, samp_r_reg;
    logic                 rise_reg;
    logic [31:0]          num_reg;
    logic [15:0]          t_reg;
    logic [16:0]          depth_reg, flo_reg, shape_reg, gain_reg;
    logic signed [SB-1:0] res_l_reg, res_r_reg;
    logic signed [PW-1:0] prod_reg;
    logic signed [SB-1:0] ol_reg, or_reg;
    logic [16:0]          og_reg;

    // saturated configuration
    logic [31:0] shift_add;
    logic [16:0] amt_sat;
    logic        bypass;
    logic        ch1_active;

    assign shift_add  = cfg.phase_shift[16] ? 32'd0 : {cfg.phase_shift[15:0], 16'd0};
    assign amt_sat    = cfg.pump_amount[16] ? UNITY : cfg.pump_amount;
    assign bypass     = (amt_sat <= BYPASS_MAX);
    assign ch1_active = (CHANNELS >= 2) && (cfg.active_channels >= 2'd2);

    // quotient numerator, phase within its segment
    logic [31:0] p_minus_d;
    logic        p_rise;
    assign p_minus_d = p_reg - SPLIT_D;
    assign p_rise    = (p_reg >= SPLIT_D);

    // reciprocal estimate is t or t-1, one compare fixes it
    logic [31:0] divisor;
    logic [17:0] recip;
    logic [48:0] resid;
    logic        t_fix;
    assign divisor = rise_reg ? SPLIT_R : SPLIT_D;
    assign recip   = rise_reg ? RECIP_R : RECIP_D;
    assign resid   = {1'b0, num_reg, 16'd0} - {1'b0, prod_reg[47:0]};
    assign t_fix   = (resid >= {17'd0, divisor});

    // shared multiplier operand select
    logic signed [MAW-1:0] mul_a;
    logic signed [MBW-1:0] mul_b;
    logic [16:0]           fall;
    logic [17:0]           smooth_k;
    assign fall     = UNITY - {1'b0, t_reg};
    assign smooth_k = SMOOTH_3 - {1'b0, t_reg, 1'b0};

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            OP_AMT_SQ: begin
                mul_a = {{(MAW-17){1'b0}}, amt_sat};
                mul_b = {2'b00, amt_sat};
            end
            OP_FLOOR: begin
                mul_a = {{(MAW-17){1'b0}}, depth_reg};
                mul_b = {2'b00, NINE_TENTHS};
            end
            OP_RECIP: begin
                mul_a = {{(MAW-32){1'b0}}, num_reg};
                mul_b = {1'b0, recip};
            end
            OP_BACK: begin
                mul_a = {{(MAW-32){1'b0}}, divisor};
                mul_b = {3'b000, t_reg};
            end
            OP_SHAPE1: begin
                if (rise_reg) begin
                    mul_a = {{(MAW-16){1'b0}}, t_reg};
                    mul_b = {3'b000, t_reg};
                end else begin
                    mul_a = {{(MAW-17){1'b0}}, fall};
                    mul_b = {2'b00, fall};
                end
            end
            OP_SHAPE2: begin
                mul_a = {{(MAW-17){1'b0}}, shape_reg};
                mul_b = {1'b0, smooth_k};
            end
            OP_GAIN: begin
                mul_a = {{(MAW-17){1'b0}}, UNITY - flo_reg};
                mul_b = {2'b00, shape_reg};
            end
            OP_LEFT: begin
                mul_a = {{(MAW-SB){samp_l_reg[SB-1]}}, samp_l_reg};
                mul_b = {2'b00, gain_reg};
            end
            OP_RIGHT: begin
                mul_a = {{(MAW-SB){samp_r_reg[SB-1]}}, samp_r_reg};
                mul_b = {2'b00, gain_reg};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // rounded product, floor of (prod + half) / 2^16
    logic signed [PW-1:0] rnd, rsh;
    logic [16:0]          fl_sub, fl_val, gain_val;
    logic [17:0]          sm_val;
    assign rnd      = prod_reg + PW'(ROUND_HALF);
    assign rsh      = rnd >>> FRAC_BITS;
    assign fl_sub   = UNITY - rsh[16:0];
    assign fl_val   = (fl_sub < FLOOR_MIN) ? FLOOR_MIN : fl_sub;
    assign sm_val   = rsh[17:0];
    assign gain_val = bypass ? UNITY : (flo_reg + rsh[16:0]);

    // phase accumulator
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= '0;
        end else if (cmd.take) begin
            phase_reg <= phase_reg + cfg.phase_step;
        end
    end

    // work registers
    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            p_reg      <= phase_reg + shift_add;
            samp_l_reg <= in_left;
            samp_r_reg <= in_right;
        end
        if (cmd.prep) begin
            rise_reg <= p_rise;
            num_reg  <= p_rise ? p_minus_d : p_reg;
        end
        if (cmd.mul_en) begin
            prod_reg <= PW'(mul_a * mul_b);
        end
        if (cmd.wb_en) begin
            case (cmd.op)
                OP_AMT_SQ: depth_reg <= rsh[16:0];
                OP_FLOOR:  flo_reg   <= fl_val;
                OP_RECIP:  t_reg     <= prod_reg[RECIP_SHIFT +: 16];
                OP_BACK: begin
                    if (t_fix) begin
                        t_reg <= t_reg + 16'd1;
                    end
                end
                OP_SHAPE1: shape_reg <= rsh[16:0];
                OP_SHAPE2: begin
                    if (rise_reg) begin
                        shape_reg <= (sm_val > {1'b0, UNITY}) ? UNITY : sm_val[16:0];
                    end
                end
                OP_GAIN:   gain_reg  <= gain_val;
                OP_LEFT:   res_l_reg <= rsh[SB-1:0];
                OP_RIGHT:  res_r_reg <= ch1_active ? rsh[SB-1:0] : '0;
                default: begin
                end
            endcase
        end
    end

    // output register, parts the work from the master side
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            ol_reg <= res_l_reg;
            or_reg <= res_r_reg;
            og_reg <= gain_reg;
        end
    end

    assign out_left  = ol_reg;
    assign out_right = or_reg;
    assign gain_now  = og_reg;

endmodule

/* hdl/tsgp_ctrl.sv */
module tsgp_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    output logic           m_tvalid,
    input  logic           m_tready,
    output tsgp_pkg::cmd_t cmd
);
    import tsgp_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_PREP = 5'b00010,
        ST_MUL  = 5'b00100,
        ST_WB   = 5'b01000,
        ST_OUT  = 5'b10000
    } state_t;

    state_t  state_reg, state_next;
    mul_op_t op_reg, op_next;
    logic    tvalid_reg, tvalid_next;

    assign s_tready = aresetn && (state_reg == ST_IDLE);
    assign m_tvalid = tvalid_reg;

    // sequencer
    always_comb begin
        state_next = state_reg;
        op_next    = op_reg;
        cmd        = '0;
        cmd.op     = op_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.take   = 1'b1;
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                cmd.prep   = 1'b1;
                op_next    = OP_AMT_SQ;
                state_next = ST_MUL;
            end
            ST_MUL: begin
                cmd.mul_en = 1'b1;
                state_next = ST_WB;
            end
            ST_WB: begin
                cmd.wb_en = 1'b1;
                case (op_reg)
                    OP_AMT_SQ: begin
                        op_next    = OP_FLOOR;
                        state_next = ST_MUL;
                    end
                    OP_FLOOR: begin
                        op_next    = OP_RECIP;
                        state_next = ST_MUL;
                    end
                    OP_RECIP: begin
                        op_next    = OP_BACK;
                        state_next = ST_MUL;
                    end
                    OP_BACK: begin
                        op_next    = OP_SHAPE1;
                        state_next = ST_MUL;
                    end
                    OP_SHAPE1: begin
                        op_next    = OP_SHAPE2;
                        state_next = ST_MUL;
                    end
                    OP_SHAPE2: begin
                        op_next    = OP_GAIN;
                        state_next = ST_MUL;
                    end
                    OP_GAIN: begin
                        op_next    = OP_LEFT;
                        state_next = ST_MUL;
                    end
                    OP_LEFT: begin
                        op_next    = OP_RIGHT;
                        state_next = ST_MUL;
                    end
                    OP_RIGHT: begin
                        state_next = ST_OUT;
                    end
                    default: begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_OUT: begin
                if (!tvalid_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // result valid flag
    always_comb begin
        tvalid_next = tvalid_reg;
        if (cmd.out_load) begin
            tvalid_next = 1'b1;
        end else if (m_tready) begin
            tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            op_reg     <= OP_AMT_SQ;
            tvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            op_reg     <= op_next;
            tvalid_reg <= tvalid_next;
        end
    end

    // a result never overwrites one still waiting
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!tvalid_reg || m_tready))
        else $error("output register loaded while occupied");

    // an accepted frame starts the division setup next
    a_take_prep: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == ST_PREP))
        else $error("accepted frame did not start");

    // every writeback follows its multiply
    a_wb_after_mul: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WB) |-> ($past(state_reg) == ST_MUL))
        else $error("writeback without multiply");

    // the reciprocal estimate is always followed by its correction multiply
    a_recip_back: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WB && op_reg == OP_RECIP)
        |=> (state_reg == ST_MUL && op_reg == OP_BACK))
        else $error("quotient correction out of sequence");

endmodule

/* hdl/tempo_synced_gain_pump_top.sv */
// a frame runs prep, multiply, writeback and output states before m_tvalid rises
// frames are taken one at a time, only in the idle state, as the one shared
//   multiplier runs nine products in turn, a multiply and a writeback state for each
// a finished result waits in the output register while the next frame runs;
//   the controller holds before its output load while that register is full
// reset (aresetn low, synchronous): phase zero, registers to defaults, no result
module tempo_synced_gain_pump_top #(
    parameter int CHANNELS    = tsgp_pkg::DEF_CHANNELS,
    parameter int SAMPLE_BITS = tsgp_pkg::DEF_SAMPLE_BITS
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // sample_left, sample_right
    input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0] s_tdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // out_left, out_right, gain_now
    output logic [((2*SAMPLE_BITS+24)/8)*8-1:0] m_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [tsgp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tsgp_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import tsgp_pkg::*;

    localparam int OW = ((2*SAMPLE_BITS+24)/8)*8;

    cfg_t cfg_reg;
    cmd_t cmd;

    logic signed [SAMPLE_BITS-1:0] in_left, in_right, out_left, out_right;
    logic [16:0]                   gain_now;

    assign cfg_ready = aresetn;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.phase_step      <= RST_PHASE_STEP;
            cfg_reg.phase_shift     <= RST_PHASE_SHIFT;
            cfg_reg.pump_amount     <= RST_PUMP_AMOUNT;
            cfg_reg.active_channels <= RST_ACTIVE_CHANNELS;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_PHASE_STEP:      cfg_reg.phase_step      <= cfg_data[31:0];
                REG_PHASE_SHIFT:     cfg_reg.phase_shift     <= cfg_data[16:0];
                REG_PUMP_AMOUNT:     cfg_reg.pump_amount     <= cfg_data[16:0];
                REG_ACTIVE_CHANNELS: cfg_reg.active_channels <= cfg_data[1:0];
                default: begin
                end
            endcase
        end
    end

    // payload unpack and pack
    assign in_left  = s_tdata[SAMPLE_BITS-1:0];
    assign in_right = s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
    assign m_tdata  = OW'({gain_now, out_right, out_left});

    tsgp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    tsgp_dp #(
        .CHANNELS    (CHANNELS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .cmd       (cmd),
        .in_left   (in_left),
        .in_right  (in_right),
        .out_left  (out_left),
        .out_right (out_right),
        .gain_now  (gain_now)
    );

endmodule
